// ----- rtl/btpc_pkg.sv -----
// Shared types, constants and wrapping multiply helpers for the barometer compensation
`timescale 1ns / 1ps
`default_nettype none
package btpc_pkg;

  // Calibration words unpacked from the four configuration registers
  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } cal_t;

  // Control and side data that travel with an item down the pipeline
  typedef struct packed {
    logic        vld;
    logic        inv;
    logic        neg;
    logic [14:0] temp;
  } side_t;

  localparam int unsigned        DivWidth   = 64;
  localparam logic signed [25:0] FineOffset = 26'sd128000;
  localparam logic signed [19:0] TempMin    = -20'sd4000;
  localparam logic signed [19:0] TempMax    = 20'sd8500;
  localparam logic [20:0]        PressFull  = 21'd1048576;
  localparam logic [63:0]        PolyBias   = 64'h0000_8000_0000_0000;
  localparam logic [16:0]        DivScale   = 17'd3125;
  localparam logic [24:0]        PressMax   = 25'h1FF_FFFF;

  // Low 32-bit half of x times signed y, exact
  function automatic logic [49:0] mul_lo(input logic [63:0] x, input logic [16:0] y);
    logic signed [32:0] xl;
    logic signed [49:0] pr;
    xl = $signed({1'b0, x[31:0]});
    pr = xl * $signed(y);
    return pr;
  endfunction

  // High 32-bit half of x times signed y, only the bits that survive mod 2^64
  function automatic logic [31:0] mul_hi(input logic [63:0] x, input logic [16:0] y);
    logic signed [31:0] xh;
    logic signed [31:0] pr;
    xh = $signed(x[63:32]);
    pr = xh * $signed(y);
    return pr;
  endfunction

  // Combine the two halves into the product mod 2^64
  function automatic logic [63:0] mul_sum(input logic [49:0] lo, input logic [31:0] hi);
    return {hi, 32'd0} + {{14{lo[49]}}, lo};
  endfunction

  // Arithmetic right shift of a 64-bit word
  function automatic logic [63:0] asr(input logic [63:0] v, input int unsigned n);
    return $signed(v) >>> n;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/btpc_temp.sv -----
// Temperature stages: fine temperature, compensated temperature, pressure offset term
`timescale 1ns / 1ps
`default_nettype none
module btpc_temp import btpc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_vld,
  input  wire logic [19:0]        temp_code,
  input  wire logic [19:0]        press_code,
  input  wire cal_t               cal,
  output side_t                   side_out,
  output logic signed [25:0]      a_out,
  output logic [19:0]             rp_out
);

  logic signed [33:0] m1;
  logic signed [33:0] dd;
  logic signed [22:0] v1;
  logic signed [36:0] m2;
  logic signed [24:0] fine;
  logic signed [25:0] a;
  logic [14:0]        temp;
  logic [19:0]        rp [1:4];
  logic [3:0]         vld;

  logic signed [17:0] dif;
  logic signed [16:0] dt;
  logic signed [27:0] fx;
  logic signed [27:0] t5;
  logic signed [19:0] tq;
  logic [14:0]        temp_next;

  always_comb begin
    dif = $signed({1'b0, temp_code[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
    dt  = $signed({1'b0, temp_code[19:4]}) - $signed({1'b0, cal.t1});
    fx  = $signed({{3{fine[24]}}, fine});
    t5  = (fx <<< 2) + fx + 28'sd128;
    tq  = t5[27:8];
    // clamp to the output range
    if (tq < TempMin) begin
      temp_next = TempMin[14:0];
    end else if (tq > TempMax) begin
      temp_next = TempMax[14:0];
    end else begin
      temp_next = tq[14:0];
    end
  end

  // advance the four temperature stages
  always_ff @(posedge clk) begin
    m1    <= dif * $signed(cal.t2);
    dd    <= dt * dt;
    v1    <= m1[33:11];
    m2    <= $signed({1'b0, dd[31:12]}) * $signed(cal.t3);
    fine  <= $signed({{2{v1[22]}}, v1}) + $signed({{2{m2[36]}}, m2[36:14]});
    a     <= $signed({fine[24], fine}) - FineOffset;
    temp  <= temp_next;
    rp[1] <= press_code;
    rp[2] <= rp[1];
    rp[3] <= rp[2];
    rp[4] <= rp[3];
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], in_vld};
    end
  end

  assign side_out = '{vld: vld[3], inv: 1'b0, neg: 1'b0, temp: temp};
  assign a_out    = a;
  assign rp_out   = rp[4];

endmodule
`default_nettype wire

// ----- rtl/btpc_coef.sv -----
// Pressure polynomial stages: divisor, dividend and their magnitudes for the divider
`timescale 1ns / 1ps
`default_nettype none
module btpc_coef import btpc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire side_t              side_in,
  input  wire logic signed [25:0] a_in,
  input  wire logic [19:0]        rp_in,
  input  wire cal_t               cal,
  output side_t                   side_out,
  output logic [63:0]             num_out,
  output logic [63:0]             den_out
);

  side_t              sd [1:8];
  logic [19:0]        rp [1:4];
  logic signed [51:0] aa;
  logic signed [41:0] ap5 [1:3];
  logic signed [41:0] ap2 [1:3];
  logic [49:0]        pl6, pl3, pl1, pln;
  logic [31:0]        ph6, ph3, ph1, phn;
  logic [63:0]        aap6, aap3, b, xa, n0, av, av7, n;
  logic [63:0]        mn, md;

  logic [63:0] aax;
  logic [20:0] pn;
  side_t       sd7_next, sd8_next;

  always_comb begin
    aax = {{12{aa[51]}}, aa};
    pn  = PressFull - {1'b0, rp[4]};
    sd7_next     = sd[6];
    sd7_next.inv = (av == 64'd0);
    sd8_next     = sd[7];
    sd8_next.neg = n[63] ^ av7[63];
  end

  // advance the eight polynomial stages
  always_ff @(posedge clk) begin
    // square and linear terms
    aa     <= a_in * a_in;
    ap5[1] <= a_in * $signed(cal.p5);
    ap2[1] <= a_in * $signed(cal.p2);
    // partial products of the square term
    pl6    <= mul_lo(aax, {cal.p6[15], cal.p6});
    ph6    <= mul_hi(aax, {cal.p6[15], cal.p6});
    pl3    <= mul_lo(aax, {cal.p3[15], cal.p3});
    ph3    <= mul_hi(aax, {cal.p3[15], cal.p3});
    ap5[2] <= ap5[1];
    ap2[2] <= ap2[1];
    aap6   <= mul_sum(pl6, ph6);
    aap3   <= mul_sum(pl3, ph3);
    ap5[3] <= ap5[2];
    ap2[3] <= ap2[2];
    // sum the polynomial terms
    b  <= aap6 + ({{22{ap5[3][41]}}, ap5[3]} << 17) + ({{48{cal.p4[15]}}, cal.p4} << 35);
    xa <= PolyBias + asr(aap3, 8) + ({{22{ap2[3][41]}}, ap2[3]} << 12);
    // scale by P1 and form the dividend
    pl1 <= mul_lo(xa, {1'b0, cal.p1});
    ph1 <= mul_hi(xa, {1'b0, cal.p1});
    n0  <= ({43'd0, pn} << 31) - b;
    av  <= asr(mul_sum(pl1, ph1), 33);
    pln <= mul_lo(n0, DivScale);
    phn <= mul_hi(n0, DivScale);
    n   <= mul_sum(pln, phn);
    av7 <= av;
    // magnitudes for the unsigned divider
    mn  <= n[63] ? (~n + 64'd1) : n;
    md  <= av7[63] ? (~av7 + 64'd1) : av7;
    rp[1] <= rp_in;
    rp[2] <= rp[1];
    rp[3] <= rp[2];
    rp[4] <= rp[3];
    // carry the side data, dropped in reset
    if (rst) begin
      for (int i = 1; i <= 8; i++) begin
        sd[i] <= '0;
      end
    end else begin
      sd[1] <= side_in;
      sd[2] <= sd[1];
      sd[3] <= sd[2];
      sd[4] <= sd[3];
      sd[5] <= sd[4];
      sd[6] <= sd[5];
      sd[7] <= sd7_next;
      sd[8] <= sd8_next;
    end
  end

  assign side_out = sd[8];
  assign num_out  = mn;
  assign den_out  = md;

endmodule
`default_nettype wire

// ----- rtl/btpc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module btpc_div import btpc_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire side_t               side_in,
  input  wire logic [DivWidth-1:0] num_in,
  input  wire logic [DivWidth-1:0] den_in,
  output side_t                    side_out,
  output logic [DivWidth-1:0]      quo_out
);

  side_t               sd  [0:DivWidth];
  logic [DivWidth-1:0] rem [0:DivWidth];
  logic [DivWidth-1:0] quo [0:DivWidth];
  logic [DivWidth-1:0] den [0:DivWidth];

  assign sd[0]  = side_in;
  assign rem[0] = '0;
  assign quo[0] = num_in;
  assign den[0] = den_in;

  for (genvar i = 0; i < DivWidth; i++) begin : g_stage
    logic [DivWidth:0] shf;
    logic [DivWidth:0] dif;

    // trial subtract of the divisor from the shifted remainder
    always_comb begin
      shf = {rem[i], quo[i][DivWidth-1]};
      dif = shf - {1'b0, den[i]};
    end

    always_ff @(posedge clk) begin
      rem[i+1] <= dif[DivWidth] ? shf[DivWidth-1:0] : dif[DivWidth-1:0];
      quo[i+1] <= {quo[i][DivWidth-2:0], ~dif[DivWidth]};
      den[i+1] <= den[i];
      if (rst) begin
        sd[i+1] <= '0;
      end else begin
        sd[i+1] <= sd[i];
      end
    end
  end

  assign side_out = sd[DivWidth];
  assign quo_out  = quo[DivWidth];

endmodule
`default_nettype wire

// ----- rtl/btpc_post.sv -----
// Pressure correction stages after the division, saturation and result register
`timescale 1ns / 1ps
`default_nettype none
module btpc_post import btpc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire side_t       side_in,
  input  wire logic [63:0] quo_in,
  input  wire cal_t        cal,
  output logic             done,
  output logic [14:0]      temperature_centi,
  output logic [24:0]      pressure_q8,
  output logic             pressure_invalid
);

  side_t       sd [1:6];
  logic [63:0] p  [1:5];
  logic [63:0] e  [3:5];
  logic [63:0] ll;
  logic [31:0] lh;
  logic [49:0] pl8, pl9;
  logic [31:0] ph8, ph9;
  logic [63:0] sq, c, s;

  logic [63:0] ps;
  logic [63:0] r;
  logic [24:0] press_next;

  always_comb begin
    ps = asr(p[1], 13);
    r  = asr(s, 8) + ({{48{cal.p7[15]}}, cal.p7} << 4);
    // clamp, and force zero for a zero divisor
    if (sd[6].inv || r[63]) begin
      press_next = '0;
    end else if (r > {39'd0, PressMax}) begin
      press_next = PressMax;
    end else begin
      press_next = r[24:0];
    end
  end

  // advance the correction stages
  always_ff @(posedge clk) begin
    p[1] <= side_in.neg ? (~quo_in + 64'd1) : quo_in;
    // square of the scaled quotient and the P8 term
    ll   <= ps[31:0] * ps[31:0];
    lh   <= ps[31:0] * ps[63:32];
    pl8  <= mul_lo(p[1], {cal.p8[15], cal.p8});
    ph8  <= mul_hi(p[1], {cal.p8[15], cal.p8});
    p[2] <= p[1];
    sq   <= ll + {lh[30:0], 33'd0};
    e[3] <= asr(mul_sum(pl8, ph8), 19);
    p[3] <= p[2];
    pl9  <= mul_lo(sq, {cal.p9[15], cal.p9});
    ph9  <= mul_hi(sq, {cal.p9[15], cal.p9});
    e[4] <= e[3];
    p[4] <= p[3];
    c    <= asr(mul_sum(pl9, ph9), 25);
    e[5] <= e[4];
    p[5] <= p[4];
    s    <= p[5] + c + e[5];
    // result register
    temperature_centi <= sd[6].temp;
    pressure_q8       <= press_next;
    pressure_invalid  <= sd[6].inv;
    // carry the side data, dropped in reset
    if (rst) begin
      for (int i = 1; i <= 6; i++) begin
        sd[i] <= '0;
      end
      done <= 1'b0;
    end else begin
      sd[1] <= side_in;
      sd[2] <= sd[1];
      sd[3] <= sd[2];
      sd[4] <= sd[3];
      sd[5] <= sd[4];
      sd[6] <= sd[5];
      done  <= sd[6].vld;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/baro_temp_pressure_compensation.sv -----
// Top level: calibration registers and the compensation pipeline
`timescale 1ns / 1ps
`default_nettype none
// Takes one raw temperature and pressure reading per clock cycle whenever start is
// high (busy is only high during reset) and returns the compensated temperature in
// 0.01 degC and the pressure in Pa as Q17.8, marked by a one-cycle done strobe;
// results cannot be held off. Most of the pipeline is the 64-stage pipelined
// divider that forms the pressure quotient; the remaining stages are the
// temperature path (4), the pressure polynomial (8) and the final correction and
// saturation (7). Calibration words are written through cfg_we, cfg_index and
// cfg_data and must only change while no item is in flight.
module baro_temp_pressure_compensation import btpc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [19:0]        temp_code,
  input  wire logic [19:0]        press_code,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [47:0]        cfg_data,
  output logic                    done,
  output logic signed [14:0]      temperature_centi,
  output logic [24:0]             pressure_q8,
  output logic                    pressure_invalid
);

  localparam logic [1:0] RegTempCal   = 2'd0;
  localparam logic [1:0] RegPressLow  = 2'd1;
  localparam logic [1:0] RegPressMid  = 2'd2;
  localparam logic [1:0] RegPressHigh = 2'd3;

  logic [47:0] temp_cal, press_low, press_mid, press_high;
  cal_t        cal;

  side_t              side_t2c, side_c2d, side_d2p;
  logic signed [25:0] a_t2c;
  logic [19:0]        rp_t2c;
  logic [63:0]        num, den, quo;
  logic [14:0]        temp_out;

  // hold the calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_cal   <= '0;
      press_low  <= '0;
      press_mid  <= '0;
      press_high <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegTempCal:   temp_cal   <= cfg_data;
        RegPressLow:  press_low  <= cfg_data;
        RegPressMid:  press_mid  <= cfg_data;
        RegPressHigh: press_high <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cal = '{t1: temp_cal[15:0],   t2: temp_cal[31:16],   t3: temp_cal[47:32],
                 p1: press_low[15:0],  p2: press_low[31:16],  p3: press_low[47:32],
                 p4: press_mid[15:0],  p5: press_mid[31:16],  p6: press_mid[47:32],
                 p7: press_high[15:0], p8: press_high[31:16], p9: press_high[47:32]};

  assign busy = rst;

  btpc_temp u_temp (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (start & ~busy),
    .temp_code (temp_code),
    .press_code(press_code),
    .cal       (cal),
    .side_out  (side_t2c),
    .a_out     (a_t2c),
    .rp_out    (rp_t2c)
  );

  btpc_coef u_coef (
    .clk     (clk),
    .rst     (rst),
    .side_in (side_t2c),
    .a_in    (a_t2c),
    .rp_in   (rp_t2c),
    .cal     (cal),
    .side_out(side_c2d),
    .num_out (num),
    .den_out (den)
  );

  btpc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .side_in (side_c2d),
    .num_in  (num),
    .den_in  (den),
    .side_out(side_d2p),
    .quo_out (quo)
  );

  btpc_post u_post (
    .clk              (clk),
    .rst              (rst),
    .side_in          (side_d2p),
    .quo_in           (quo),
    .cal              (cal),
    .done             (done),
    .temperature_centi(temp_out),
    .pressure_q8      (pressure_q8),
    .pressure_invalid (pressure_invalid)
  );

  assign temperature_centi = $signed(temp_out);

endmodule
`default_nettype wire

// ----- bench/btpc_checker.sv -----
// Checker: predicts each compensation result and compares it with the block output
`timescale 1ns / 1ps
`default_nettype none
module btpc_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic [19:0]        temp_code,
  input  wire logic [19:0]        press_code,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [47:0]        cfg_data,
  input  wire logic               done,
  input  wire logic signed [14:0] temperature_centi,
  input  wire logic [24:0]        pressure_q8,
  input  wire logic               pressure_invalid,
  output int                      errors,
  output int                      pending
);

  localparam longint PressLimit = 64'd33554431;

  typedef struct packed {
    logic signed [14:0] temp;
    logic [24:0]        press;
    logic               inv;
  } reading_t;

  logic [47:0] cal_regs [4];
  reading_t    expected_readings [$];

  // Signed 16-bit slice k of a calibration register
  function automatic longint cal_s(input logic [47:0] r, input int k);
    return longint'($signed(r[16*k +: 16]));
  endfunction

  // Unsigned 16-bit slice k of a calibration register
  function automatic longint cal_u(input logic [47:0] r, input int k);
    return longint'({48'd0, r[16*k +: 16]});
  endfunction

  // Compensate one reading, 64-bit wrapping in the pressure stage
  function automatic reading_t compensate(input logic [19:0] rt_in, input logic [19:0] rp_in);
    reading_t res;
    longint rt, rp, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    longint v1, d, v2, fine, tc, a, b, p, ps, c, e, num;
    rt = longint'({44'd0, rt_in});
    rp = longint'({44'd0, rp_in});
    t1 = cal_u(cal_regs[0], 0); t2 = cal_s(cal_regs[0], 1); t3 = cal_s(cal_regs[0], 2);
    p1 = cal_u(cal_regs[1], 0); p2 = cal_s(cal_regs[1], 1); p3 = cal_s(cal_regs[1], 2);
    p4 = cal_s(cal_regs[2], 0); p5 = cal_s(cal_regs[2], 1); p6 = cal_s(cal_regs[2], 2);
    p7 = cal_s(cal_regs[3], 0); p8 = cal_s(cal_regs[3], 1); p9 = cal_s(cal_regs[3], 2);
    // temperature stage
    v1 = (((rt >>> 3) - 2 * t1) * t2) >>> 11;
    d = (rt >>> 4) - t1;
    v2 = (((d * d) >>> 12) * t3) >>> 14;
    fine = v1 + v2;
    tc = (fine * 5 + 128) >>> 8;
    if (tc < -4000) tc = -4000;
    if (tc > 8500) tc = 8500;
    res.temp = tc[14:0];
    // pressure polynomial
    a = fine - 128000;
    b = a * a * p6;
    b = b + ((a * p5) <<< 17);
    b = b + (p4 <<< 35);
    a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
    a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
    res.press = '0;
    res.inv = 1'b0;
    if (a == 0) begin
      res.inv = 1'b1;
    end else begin
      p = 1048576 - rp;
      num = ((p <<< 31) - b) * 3125;
      // negate instead of dividing by minus one to keep the wrap defined
      if (a == -1) p = -num;
      else p = num / a;
      ps = p >>> 13;
      c = (p9 * ps * ps) >>> 25;
      e = (p8 * p) >>> 19;
      p = ((p + c + e) >>> 8) + (p7 <<< 4);
      if (p < 0) p = 0;
      if (p > PressLimit) p = PressLimit;
      res.press = p[24:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  assign pending = expected_readings.size();

  // Track writes, queue predictions, check results
  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      for (int i = 0; i < 4; i++) cal_regs[i] <= '0;
      expected_readings.delete();
    end else begin
      if (cfg_we) cal_regs[cfg_index] <= cfg_data;
      if (start && !busy) expected_readings.push_back(compensate(temp_code, press_code));
      if (done) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          want = expected_readings.pop_front();
          if (temperature_centi !== want.temp)
            report_mismatch($sformatf("temperature_centi %0d, want %0d",
                                      temperature_centi, want.temp));
          if (pressure_q8 !== want.press)
            report_mismatch($sformatf("pressure_q8 %0d, want %0d", pressure_q8, want.press));
          if (pressure_invalid !== want.inv)
            report_mismatch($sformatf("pressure_invalid %0b, want %0b",
                                      pressure_invalid, want.inv));
        end
      end
    end
  end

  initial errors = 0;

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
// Testbench top: stimulus, calibration phases and verdict for the compensation block
`timescale 1ns / 1ps
`default_nettype none
module tb;

  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 100;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [19:0]        temp_code = '0;
  logic [19:0]        press_code = '0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [47:0]        cfg_data = '0;
  logic               done;
  logic signed [14:0] temperature_centi;
  logic [24:0]        pressure_q8;
  logic               pressure_invalid;
  int                 errors;
  int                 pending;
  int                 cycles = 0;
  int                 idle_pct = 0;

  always #4 clk = ~clk;

  baro_temp_pressure_compensation uut (
    .clk, .rst, .start, .busy, .temp_code, .press_code, .cfg_we, .cfg_index, .cfg_data,
    .done, .temperature_centi, .pressure_q8, .pressure_invalid
  );

  btpc_checker chk (
    .clk, .rst, .start, .busy, .temp_code, .press_code, .cfg_we, .cfg_index, .cfg_data,
    .done, .temperature_centi, .pressure_q8, .pressure_invalid, .errors, .pending
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("** baro_temp_pressure_compensation: FAILED **");
      $finish;
    end
  end

  // Offer one item, with a random gap first, and hold it until accepted
  task automatic send_reading(input logic [19:0] rt, input logic [19:0] rp);
    bit taken;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    temp_code <= rt;
    press_code <= rp;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
  endtask

  // Drain outstanding items, then load all four calibration registers
  task automatic load_calibration(input logic [47:0] c0, input logic [47:0] c1,
                                  input logic [47:0] c2, input logic [47:0] c3);
    logic [47:0] vals [4];
    vals = '{c0, c1, c2, c3};
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Readings near the usual sensor range, with some full-range noise
  task automatic random_readings(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 70)
        send_reading(20'($urandom_range(380000, 620000)), 20'($urandom_range(200000, 700000)));
      else
        send_reading(20'($urandom), 20'($urandom));
    end
  endtask

  localparam logic [47:0] TypTemp = {16'hFC18, 16'd26435, 16'd27504};
  localparam logic [47:0] TypLow  = {16'd3024, 16'hD643, 16'd36477};
  localparam logic [47:0] TypMid  = {16'hFFF9, 16'd140, 16'd2855};
  localparam logic [47:0] TypHigh = {16'd6000, 16'hC6F8, 16'd15500};

  initial begin
    int pcts [4];
    pcts = '{0, 46, 0, 34};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset calibration: zero divisor on every item
    send_reading(20'h00000, 20'h00000);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'h00000, 20'hFFFFF);
    send_reading(20'hFFFFF, 20'h00000);

    // typical calibration, field extremes and ordinary readings
    load_calibration(TypTemp, TypLow, TypMid, TypHigh);
    send_reading(20'h00000, 20'h00000);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'h00000, 20'hFFFFF);
    send_reading(20'hFFFFF, 20'h00000);
    send_reading(20'd519888, 20'd415148);
    send_reading(20'd400000, 20'd300000);
    send_reading(20'd600000, 20'd600000);
    send_reading(20'h55555, 20'hAAAAA);
    send_reading(20'hAAAAA, 20'h55555);
    send_reading(20'd200000, 20'd100000);

    // calibration sweep: typical, extremes, then random sets
    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = pcts[ph % 4];
      case (ph)
        0: load_calibration(TypTemp, TypLow, TypMid, TypHigh);
        1: load_calibration('1, '1, '1, '1);
        2: load_calibration('0, '0, '0, '0);
        3: load_calibration({16'h7FFF, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h7FFF, 16'hFFFF},
                            {3{16'h7FFF}}, {3{16'h7FFF}});
        4: load_calibration({16'h8000, 16'h8000, 16'h0001}, {16'h8000, 16'h8000, 16'h0001},
                            {3{16'h8000}}, {3{16'h8000}});
        default: load_calibration(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                                  48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
      endcase
      random_readings(130);
    end

    // drain and give the verdict
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0)
      $display("** baro_temp_pressure_compensation: PASSED **");
    else
      $display("** baro_temp_pressure_compensation: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire
